// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ilist_pkg.sv -----
// Package for the indexed list: sizes, codes, item types and control structs.
`default_nettype none
package ilist_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;

  // Fixed field widths of the item formats.
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  // Internal widths that follow the built depth.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MAX_W = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
                                         : ((POS_W > CAP_W) ? POS_W : CAP_W);
  localparam int CMP_W = MAX_W + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [FOUND_W-1:0]        found_index;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic exec;    // run the operation on the entry chain
    logic finish;  // form the result and load the output register
  } ilist_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_valid;
  } ilist_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/ilist_ctrl.sv -----
// Controller state machine for the indexed list: sequences load, execute and finish.
`default_nettype none
module ilist_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                out_stall,
  input  wire ilist_pkg::ilist_sts_t sts,
  output logic                     in_stall,
  output ilist_pkg::ilist_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !sts.out_valid || !out_stall;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // next item may enter as this result goes to the output register
        in_stall   = !out_free;
        cmd.finish = out_free;
        accept     = in_valid && out_free;
        if (out_free) state_next = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.load = accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ilist_dp.sv -----
// Datapath for the indexed list: entry chain, count, capacity and result register.
`default_nettype none
module ilist_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ilist_pkg::ilist_cmd_t cmd,
  input  wire logic                  cfg_we,
  input  wire logic [ilist_pkg::CAP_W-1:0] cfg_data,
  input  wire ilist_pkg::in_item_t   in_item,
  input  wire logic                  out_stall,
  output ilist_pkg::out_item_t       out_item,
  output logic                       out_valid,
  output ilist_pkg::ilist_sts_t      sts
);

  localparam int CMP_W = ilist_pkg::CMP_W;
  localparam int IDX_W = ilist_pkg::IDX_W;
  localparam int CNT_W = ilist_pkg::CNT_W;
  localparam int DEPTH = ilist_pkg::DEPTH;

  ilist_pkg::word_t store      [DEPTH];
  ilist_pkg::word_t store_next [DEPTH];
  ilist_pkg::word_t up         [DEPTH];
  ilist_pkg::word_t dn         [DEPTH];

  logic [CNT_W-1:0]                 count;
  logic [CNT_W-1:0]                 count_next;
  logic [ilist_pkg::CAP_W-1:0]      cap;
  logic [ilist_pkg::FUNC_W-1:0]     cur_func;
  logic [ilist_pkg::POS_W-1:0]      cur_pos;
  ilist_pkg::word_t                 cur_word;
  logic [ilist_pkg::STAT_W-1:0]     stat_q;
  logic [ilist_pkg::STAT_W-1:0]     stat_next;
  logic [DEPTH-1:0]                 match_q;
  logic [DEPTH-1:0]                 match_next;
  ilist_pkg::word_t                 read_q;
  ilist_pkg::word_t                 read_next;
  ilist_pkg::out_item_t             out_q;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] cap_c;
  logic [CMP_W-1:0] lim_c;
  logic [CMP_W-1:0] p0;
  logic             full;
  logic             ins_ok;
  logic             rd_ok;
  logic             do_app;
  logic             do_ins;
  logic             do_rem;
  logic             do_rd;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  ilist_pkg::out_item_t res;

  assign pos_c  = CMP_W'(cur_pos);
  assign cnt_c  = CMP_W'(count);
  assign cap_c  = CMP_W'(cap);
  assign lim_c  = (cap_c > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_c;
  assign p0     = pos_c - CMP_W'(1);
  assign full   = cnt_c >= lim_c;
  assign ins_ok = (pos_c >= CMP_W'(1)) && (pos_c <= cnt_c + CMP_W'(1));
  assign rd_ok  = (pos_c >= CMP_W'(1)) && (pos_c <= cnt_c);
  assign rd_idx = p0[IDX_W-1:0];

  // Operation decode and status for everything but search.
  always_comb begin
    do_app    = 1'b0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_rd     = 1'b0;
    stat_next = ilist_pkg::ST_OK;
    case (cur_func)
      ilist_pkg::FN_APPEND: begin
        if (full) stat_next = ilist_pkg::ST_FULL;
        else      do_app = 1'b1;
      end
      ilist_pkg::FN_INSERT: begin
        if (full)         stat_next = ilist_pkg::ST_FULL;
        else if (!ins_ok) stat_next = ilist_pkg::ST_RANGE;
        else              do_ins = 1'b1;
      end
      ilist_pkg::FN_REMOVE: begin
        if (!rd_ok) stat_next = ilist_pkg::ST_RANGE;
        else        do_rem = 1'b1;
      end
      ilist_pkg::FN_READ: begin
        if (!rd_ok) stat_next = ilist_pkg::ST_RANGE;
        else        do_rd = 1'b1;
      end
      default: begin
        stat_next = ilist_pkg::ST_OK;
      end
    endcase
  end

  // Neighbour taps for shifting up and down.
  always_comb begin
    up[0]       = store[0];
    dn[DEPTH-1] = store[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      up[i]   = store[i-1];
      dn[i-1] = store[i];
    end
  end

  always_comb begin
    logic [CMP_W-1:0] idx;
    for (int i = 0; i < DEPTH; i++) begin
      idx = CMP_W'(i);
      store_next[i] = store[i];
      if (do_app && idx == cnt_c) begin
        store_next[i] = cur_word;
      end else if (do_ins) begin
        if (idx == p0)                      store_next[i] = cur_word;
        else if (idx > p0 && idx <= cnt_c)  store_next[i] = up[i];
      end else if (do_rem) begin
        if (idx >= p0 && idx + CMP_W'(1) < cnt_c) store_next[i] = dn[i];
      end
      match_next[i] = (idx < cnt_c) && (store[i] == cur_word);
    end
  end

  always_comb begin
    count_next = count;
    if (do_app || do_ins) count_next = count + CNT_W'(1);
    else if (do_rem)      count_next = count - CNT_W'(1);
  end

  assign read_next = do_rd ? store[rd_idx] : '0;

  // First match wins: scan from the top so the lowest index is left.
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IDX_W'(i);
    end
  end
  assign hit_any = |match_q;

  always_comb begin
    res.status      = stat_q;
    res.found_index = '0;
    res.read_value  = ilist_pkg::VALUE_W'(read_q);
    res.count       = ilist_pkg::COUNT_W'(count);
    if (cur_func == ilist_pkg::FN_SEARCH) begin
      res.status = hit_any ? ilist_pkg::ST_OK : ilist_pkg::ST_NOTFOUND;
      if (hit_any) res.found_index = ilist_pkg::FOUND_W'(hit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      store   <= store_next;
      match_q <= match_next;
      read_q  <= read_next;
      stat_q  <= stat_next;
    end
    if (cmd.load) begin
      cur_func <= in_item.func;
      cur_pos  <= in_item.position;
      cur_word <= ilist_pkg::WORD_BITS'(in_item.value);
    end
    if (cmd.finish) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap       <= ilist_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we)   cap   <= cfg_data;
      if (cmd.exec) count <= count_next;
      if (cmd.finish)      out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign out_item      = out_q;
  assign sts.out_valid = out_valid;

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_insert_remove_search.sv -----
// Top level of the indexed list: controller, datapath and checks.
`default_nettype none
`include "assert_macros.svh"
// Bounded ordered list of up to 64 signed 32-bit words held in a register chain.
// Each item runs one operation (append, insert at a 1-based position, remove at a
// 1-based position, search for the first index holding a key, or read) and gives
// exactly one result with status and count. Each item passes through an execute
// state in which every entry shifts and is compared in parallel, and a finish state
// that encodes the first search match and loads the output register. The next item is
// taken in the finish state when the output register is free; a stalled result holds
// the block once it is complete. The capacity register limits the entries in use to
// min(capacity, 64) and should be written only while the block is idle.
module indexed_list_insert_remove_search (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire ilist_pkg::in_item_t          in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ilist_pkg::out_item_t              out_item,
  input  wire logic                         cfg_we,
  input  wire logic [ilist_pkg::CAP_W-1:0]  cfg_data
);

  ilist_pkg::ilist_cmd_t cmd;
  ilist_pkg::ilist_sts_t sts;

  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  ilist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .sts       (sts)
  );

  // an accepted item keeps the input side busy for its execute cycle
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item taken while busy")
  `ASSERT_SAME(a_count_bound, out_valid,
               out_item.count <= ilist_pkg::COUNT_W'(ilist_pkg::DEPTH), "count beyond depth")
  `ASSERT_SAME(a_notfound_index, out_valid && out_item.status == ilist_pkg::ST_NOTFOUND,
               out_item.found_index == '0, "index set on a failed search")
  `ASSERT_SAME(a_fail_no_data, out_valid && out_item.status != ilist_pkg::ST_OK,
               out_item.read_value == '0, "read data on a failed operation")

endmodule
`default_nettype wire

// ----- test/tb_indexed_list_insert_remove_search.sv -----
// Testbench for the indexed list: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove_search;
  import ilist_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;
  localparam int LONG_HOLD   = 300;
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {MIX_EVEN, MIX_GROW, MIX_SHRINK} mix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_data = '0;

  // predictor state
  word_t             list_model [DEPTH];
  int                list_len = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  out_item_t         pending_results [$];

  bit                no_idle = 1'b0;
  int                hold_req = 0;
  int                sink_wait = 0;
  int                mismatch_count = 0;
  int                items_sent = 0;
  int                results_checked = 0;
  int                caps_written = 0;
  int                longest_list = 0;
  int                status_seen [4] = '{0, 0, 0, 0};
  int                cycle_count = 0;

  indexed_list_insert_remove_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Runs one operation on the predicted list and gives the result it should produce.
  function automatic out_item_t apply_op(input in_item_t it);
    out_item_t r;
    int        lim;
    int        p;
    int        i;
    r   = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    p   = it.position;
    case (it.func)
      FN_APPEND: begin
        if (list_len >= lim) begin
          r.status = ST_FULL;
        end else begin
          list_model[list_len] = it.value;
          list_len++;
        end
      end
      FN_INSERT: begin
        // full takes priority over a bad position
        if (list_len >= lim) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i >= p; i--) list_model[i] = list_model[i-1];
          list_model[p-1] = it.value;
          list_len++;
        end
      end
      FN_REMOVE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p - 1; i < list_len - 1; i++) list_model[i] = list_model[i+1];
          list_len--;
        end
      end
      FN_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (r.status == ST_NOTFOUND && list_model[i] == it.value) begin
            r.status      = ST_OK;
            r.found_index = FOUND_W'(i);
          end
        end
      end
      FN_READ: begin
        if (p < 1 || p > list_len) r.status = ST_RANGE;
        else r.read_value = list_model[p-1];
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    status_seen[r.status]++;
    if (list_len > longest_list) longest_list = list_len;
    return r;
  endfunction

  // Shared sender; entered and left on a rising edge.
  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_op(it));
    items_sent++;
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] f, input int p, input word_t v);
    in_item_t it;
    it.func     = f;
    it.position = POS_W'(p);
    it.value    = v;
    push_item(it);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_results_done();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = c;
    caps_written++;
  endtask

  function automatic in_item_t make_item(input mix_t mix);
    in_item_t    it;
    int unsigned pick;
    int unsigned w_app;
    int unsigned w_ins;
    int unsigned w_rem;
    it = '0;
    case (mix)
      MIX_GROW: begin
        w_app = 40; w_ins = 70; w_rem = 75;
      end
      MIX_SHRINK: begin
        w_app = 8; w_ins = 16; w_rem = 75;
      end
      default: begin
        w_app = 25; w_ins = 50; w_rem = 65;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < w_app) it.func = FN_APPEND;
    else if (pick < w_ins) it.func = FN_INSERT;
    else if (pick < w_rem) it.func = FN_REMOVE;
    else if (pick < w_rem + 13) it.func = FN_SEARCH;
    else if (pick < 97) it.func = FN_READ;
    else it.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));

    case ($urandom_range(0, 9))
      0: it.position = '0;
      1: it.position = POS_W'($urandom_range(0, 127));
      2: it.position = POS_W'(list_len + 1);
      3: it.position = POS_W'(list_len);
      default: it.position = POS_W'($urandom_range(1, list_len + 1));
    endcase

    case ($urandom_range(0, 7))
      0: it.value = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      1, 2: it.value = $signed($urandom_range(0, 6)) - 32'sd3;
      3: begin
        if (list_len != 0) it.value = list_model[$urandom_range(0, list_len - 1)];
        else it.value = $urandom;
      end
      default: it.value = $urandom;
    endcase
    // searches mostly look for a key that is held
    if (it.func == FN_SEARCH && list_len != 0 && $urandom_range(0, 2) != 0)
      it.value = list_model[$urandom_range(0, list_len - 1)];
    return it;
  endfunction

  // Result sink: random hold-off per item, or a long hold when asked.
  always @(posedge clk) begin
    if (rst) begin
      sink_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        sink_wait = hold_req;
        hold_req  = 0;
      end else if (out_valid && !out_stall) begin
        sink_wait = no_idle ? 0 : $urandom_range(0, 16);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_stall <= (sink_wait != 0);
    end
  end

  task automatic compare_field(input string fname, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none, got status %0d count %0d",
                   $time, out_item.status, out_item.count);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_item.status);
        compare_field("found_index", want.found_index, out_item.found_index);
        compare_field("read_value", want.read_value, out_item.read_value);
        compare_field("count", want.count, out_item.count);
        results_checked++;
      end
    end
  end

  task automatic test_empty_list();
    send_op(FN_READ, 1, 32'sd0);
    send_op(FN_REMOVE, 1, 32'sd0);
    send_op(FN_SEARCH, 0, 32'sd0);
    send_op(FN_INSERT, 0, 32'sd5);
    send_op(FN_INSERT, 2, 32'sd5);
  endtask

  task automatic test_basic_ops();
    send_op(FN_APPEND, 0, 32'sh7fffffff);
    send_op(FN_APPEND, 127, 32'sh80000000);
    send_op(FN_INSERT, 1, 32'sd0);
    send_op(FN_INSERT, 4, -32'sd1);       // at count+1, i.e. the tail
    send_op(FN_INSERT, 2, -32'sd1);
    send_op(FN_SEARCH, 0, -32'sd1);       // duplicate: first index wins
    send_op(FN_SEARCH, 0, 32'sd5);
    send_op(FN_READ, 5, 32'sd0);
    send_op(FN_READ, 6, 32'sd0);
    send_op(FN_READ, 127, 32'sd0);
    send_op(FN_REMOVE, 1, 32'sd0);
    send_op(FN_REMOVE, 4, 32'sd0);
    send_op(FN_SPARE_HI, 127, -32'sd1);
    send_op(FN_SPARE_LO, 1, 32'sd9);
    send_op(FN_SEARCH, 0, 32'sh80000000);
  endtask

  task automatic test_capacity_limits();
    set_capacity(7'd2);                  // below the current count
    send_op(FN_APPEND, 0, 32'sd11);
    send_op(FN_INSERT, 0, 32'sd12);      // full wins over bad position
    send_op(FN_REMOVE, 2, 32'sd0);
    send_op(FN_APPEND, 0, 32'sd13);
    send_op(FN_REMOVE, 1, 32'sd0);
    send_op(FN_APPEND, 0, 32'sd42);
    set_capacity(7'd0);
    send_op(FN_INSERT, 1, 32'sd14);
    send_op(FN_READ, 2, 32'sd0);
    set_capacity(7'd127);                // saturates at the built depth
    send_op(FN_APPEND, 0, 32'sd15);
  endtask

  task automatic test_backpressure();
    wait_results_done();
    hold_req = LONG_HOLD;
    no_idle  = 1'b1;
    repeat (30) push_item(make_item(MIX_EVEN));
    no_idle = 1'b0;
    wait_results_done();
  endtask

  task automatic test_random_mix();
    logic [CAP_W-1:0] caps [12] = '{7'd127, 7'd64, 7'd3, 7'd0, 7'd40, 7'd1,
                                    7'd64, 7'd127, 7'd65, 7'd20, 7'd2, 7'd64};
    mix_t             mixes [12] = '{MIX_GROW, MIX_EVEN, MIX_EVEN, MIX_EVEN, MIX_GROW,
                                     MIX_SHRINK, MIX_EVEN, MIX_GROW, MIX_SHRINK,
                                     MIX_EVEN, MIX_EVEN, MIX_EVEN};
    int               n;
    for (int ph = 0; ph < 12; ph++) begin
      set_capacity(caps[ph]);
      no_idle = (ph % 4 == 2);
      n = $urandom_range(130, 160);
      repeat (n) push_item(make_item(mixes[ph]));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_capacity_limits();
    test_backpressure();
    test_random_mix();
    wait_results_done();
    repeat (8) @(posedge clk);
    $display("Ran %0d items, checked %0d results, %0d capacity writes, longest list %0d",
             items_sent, results_checked, caps_written, longest_list);
    $display("Statuses seen: ok %0d, full %0d, out of range %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_NOTFOUND]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ilist_pkg.sv
rtl/core/ilist_ctrl.sv
rtl/core/ilist_dp.sv
rtl/core/indexed_list_insert_remove_search.sv
test/tb_indexed_list_insert_remove_search.sv
